/* rtl/tcw_pkg.sv */
// Package for the text console writer: sequencer states, operation codes,
// register indexes and fixed character codes.
// Depends on nothing; used by text_console_writer.
`default_nettype none

package tcw_pkg;

  // Operation codes carried in the opcode field of an input transfer.
  localparam logic [2:0] OP_PRINT  = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_SETCUR = 3'd2;
  localparam logic [2:0] OP_SCROLL = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_ATTR    = 2'd2;

  // Register reset values.
  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST    = 7'd30;
  localparam logic [7:0] ATTR_RST    = 8'd15;

  // Character codes with a special meaning.
  localparam logic [7:0] PRINTABLE_MIN = 8'd32;
  localparam logic [7:0] NEWLINE_CODE  = 8'd10;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,    // clearing pass over the whole store after reset
    ST_IDLE,    // waiting for an input transfer
    ST_SCR_RD,  // scroll: read the cell one row below
    ST_SCR_WR,  // scroll: write it one row up
    ST_FILL,    // blank cells of a row range (clear, or freed bottom row)
    ST_RD_WAIT, // cell read in flight
    ST_DONE     // result ready, waiting for the output register
  } tcw_state_t;

endpackage

`default_nettype wire

/* rtl/text_console_writer.sv */
// Text console writer: a store of character/attribute cells with a cursor.
// Depends on tcw_pkg for states, operation codes and register indexes.
`default_nettype none

// The block keeps MAX_ROWS x MAX_COLS cells of 16 bits (character in the low
// byte, attribute in the high byte) in a single-port-write memory, at address
// row*MAX_COLS+col, together with a cursor. Each input transfer carries one
// operation and produces exactly one result transfer holding a status, the
// character and attribute of a read cell (zero otherwise) and the cursor
// position after the operation. After reset a clearing pass writes zero to
// every cell, one cell a cycle; no input transfer is taken during it, while
// configuration writes are taken at all times. Print, set cursor, unused
// operations and a read of a position outside the area go straight to the
// completion state; a read inside the area first waits for the registered
// memory read, clear blanks the area in use, and scroll up (also a print that
// runs past the last row) copies the rows of the area one row up and blanks
// the freed bottom row. A scroll copies each cell with a read state and then
// a write state, and a blanking sweep writes one cell a cycle. A result that
// is ready while the previous one still waits in the output register holds
// the block in the completion state until that one is taken. The result
// waits in an output register, so the next operation may start while the
// previous result has not yet been taken. Configuration is to be written
// only while the block is idle.

module text_console_writer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input channel. in_tdata, from bit 0 up: opcode[2:0], char_code[7:0],
  // target_col[6:0], target_row[5:0].
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,
  // Result channel. out_tdata, from bit 0 up: status, cell_char[7:0],
  // cell_attr[7:0], cursor_col[6:0], cursor_row[5:0], two zero bits.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,
  // Configuration write channel.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int ERW   = $clog2(MAX_ROWS + 1);

  // Input fields.
  logic [2:0] in_op;
  logic [7:0] in_char;
  logic [6:0] in_col;
  logic [5:0] in_row;

  assign in_op   = in_tdata[2:0];
  assign in_char = in_tdata[10:3];
  assign in_col  = in_tdata[17:11];
  assign in_row  = in_tdata[23:18];

  // Registers.
  tcw_pkg::tcw_state_t state_r, state_nxt;
  logic [7:0]    columns_r;
  logic [6:0]    rows_r;
  logic [7:0]    attr_r;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] sw_col_r, sw_col_nxt;
  logic [RW-1:0] sw_row_r, sw_row_nxt;
  logic [AW-1:0] ini_addr_r, ini_addr_nxt;
  logic          res_status_r, res_status_nxt;
  logic [7:0]    res_char_r, res_char_nxt;
  logic [7:0]    res_attr_r, res_attr_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [31:0]   out_tdata_r, out_tdata_nxt;

  // Cell memory.
  logic [15:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata_r;

  // Effective area: zero acts as one, anything above the maximum as the maximum.
  logic [ECW-1:0] eff_cols;
  logic [ERW-1:0] eff_rows;

  always_comb begin
    if (columns_r == 8'd0) begin
      eff_cols = ECW'(1);
    end else if (int'(columns_r) > MAX_COLS) begin
      eff_cols = ECW'(MAX_COLS);
    end else begin
      eff_cols = ECW'(columns_r);
    end
    if (rows_r == 7'd0) begin
      eff_rows = ERW'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      eff_rows = ERW'(MAX_ROWS);
    end else begin
      eff_rows = ERW'(rows_r);
    end
  end

  logic in_fire;
  logic target_inside;
  logic sw_col_last;
  logic sw_row_copy_last;
  logic sw_row_fill_last;
  logic [CW:0] col_inc;
  logic [RW:0] row_inc;
  logic        printable;
  logic        newline;
  logic        cursor_inside;

  assign in_fire          = in_tvalid && in_tready;
  assign target_inside    = (in_col < eff_cols) && (in_row < eff_rows);
  assign sw_col_last      = (ECW'(sw_col_r) == eff_cols - ECW'(1));
  assign sw_row_copy_last = (ERW'(sw_row_r) == eff_rows - ERW'(2));
  assign sw_row_fill_last = (ERW'(sw_row_r) == eff_rows - ERW'(1));
  assign col_inc          = {1'b0, cur_col_r} + 1'b1;
  assign row_inc          = {1'b0, cur_row_r} + 1'b1;
  assign printable        = (in_char >= tcw_pkg::PRINTABLE_MIN);
  assign newline          = (in_char == tcw_pkg::NEWLINE_CODE);
  assign cursor_inside    = (cur_col_r < eff_cols) && (cur_row_r < eff_rows);

  // Sequencer: next state, cursor, sweep counters and memory port.
  always_comb begin
    logic [CW:0] pcol;
    logic [RW:0] prow;

    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    sw_col_nxt     = sw_col_r;
    sw_row_nxt     = sw_row_r;
    ini_addr_nxt   = ini_addr_r;
    res_status_nxt = res_status_r;
    res_char_nxt   = res_char_r;
    res_attr_nxt   = res_attr_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(sw_row_r * MAX_COLS) + AW'(sw_col_r);
    mem_wdata      = {attr_r, 8'h00};
    mem_raddr      = AW'(in_row * MAX_COLS) + AW'(in_col);
    pcol           = {1'b0, cur_col_r};
    prow           = {1'b0, cur_row_r};

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      tcw_pkg::ST_INIT: begin
        mem_we       = 1'b1;
        mem_waddr    = ini_addr_r;
        mem_wdata    = 16'h0000;
        ini_addr_nxt = ini_addr_r + 1'b1;
        if (ini_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = tcw_pkg::STATUS_OK;
          res_char_nxt   = 8'h00;
          res_attr_nxt   = 8'h00;
          sw_col_nxt     = '0;
          sw_row_nxt     = '0;
          state_nxt      = tcw_pkg::ST_DONE;
          case (in_op)
            tcw_pkg::OP_PRINT: begin
              if (printable) begin
                // The cell is only stored when the cursor lies in the area.
                mem_we    = cursor_inside;
                mem_waddr = AW'(cur_row_r * MAX_COLS) + AW'(cur_col_r);
                mem_wdata = {attr_r, in_char};
                if (col_inc >= eff_cols) begin
                  pcol = '0;
                  prow = row_inc;
                end else begin
                  pcol = col_inc;
                end
              end else if (newline) begin
                pcol = '0;
                prow = row_inc;
              end
              cur_col_nxt = CW'(pcol);
              cur_row_nxt = RW'(prow);
              // Past the last row the cursor stays on it and the area scrolls.
              if (prow >= eff_rows) begin
                cur_row_nxt = RW'(eff_rows - ERW'(1));
                state_nxt   = (eff_rows == ERW'(1)) ? tcw_pkg::ST_FILL
                                                    : tcw_pkg::ST_SCR_RD;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              state_nxt   = tcw_pkg::ST_FILL;
            end
            tcw_pkg::OP_SETCUR: begin
              if (target_inside) begin
                cur_col_nxt = CW'(in_col);
                cur_row_nxt = RW'(in_row);
              end else begin
                res_status_nxt = tcw_pkg::STATUS_RANGE;
              end
            end
            tcw_pkg::OP_SCROLL: begin
              state_nxt = (eff_rows == ERW'(1)) ? tcw_pkg::ST_FILL
                                                : tcw_pkg::ST_SCR_RD;
            end
            tcw_pkg::OP_READ: begin
              if (target_inside) begin
                state_nxt = tcw_pkg::ST_RD_WAIT;
              end else begin
                res_status_nxt = tcw_pkg::STATUS_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      tcw_pkg::ST_SCR_RD: begin
        mem_raddr = AW'((sw_row_r + 1) * MAX_COLS) + AW'(sw_col_r);
        state_nxt = tcw_pkg::ST_SCR_WR;
      end

      tcw_pkg::ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata_r;
        state_nxt = tcw_pkg::ST_SCR_RD;
        if (sw_col_last) begin
          sw_col_nxt = '0;
          if (sw_row_copy_last) begin
            // Copy done: blank the freed bottom row.
            sw_row_nxt = RW'(eff_rows - ERW'(1));
            state_nxt  = tcw_pkg::ST_FILL;
          end else begin
            sw_row_nxt = sw_row_r + 1'b1;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end

      tcw_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (sw_col_last) begin
          sw_col_nxt = '0;
          if (sw_row_fill_last) begin
            state_nxt = tcw_pkg::ST_DONE;
          end else begin
            sw_row_nxt = sw_row_r + 1'b1;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end

      tcw_pkg::ST_RD_WAIT: begin
        res_char_nxt = mem_rdata_r[7:0];
        res_attr_nxt = mem_rdata_r[15:8];
        state_nxt    = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, 6'(cur_row_r), 7'(cur_col_r),
                            res_attr_r, res_char_r, res_status_r};
          state_nxt      = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::ST_INIT;
      ini_addr_r   <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      out_tvalid_r <= 1'b0;
      columns_r    <= tcw_pkg::COLUMNS_RST;
      rows_r       <= tcw_pkg::ROWS_RST;
      attr_r       <= tcw_pkg::ATTR_RST;
    end else begin
      state_r      <= state_nxt;
      ini_addr_r   <= ini_addr_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcw_pkg::CFG_COLUMNS: columns_r <= cfg_data;
          tcw_pkg::CFG_ROWS:    rows_r    <= cfg_data[6:0];
          tcw_pkg::CFG_ATTR:    attr_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sw_col_r     <= sw_col_nxt;
    sw_row_r     <= sw_row_nxt;
    res_status_r <= res_status_nxt;
    res_char_r   <= res_char_nxt;
    res_attr_r   <= res_attr_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == tcw_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  // Every accepted operation leaves the idle state, so the input closes after a transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted on two consecutive cycles");

  // Writes never leave the store, also for area sizes that are not powers of two.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < DEPTH))
    else $error("cell write outside the store");

  // A new result only comes from the completion state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r)) |-> $past(state_r == tcw_pkg::ST_DONE))
    else $error("result raised outside completion");

endmodule

`default_nettype wire

/* verif/text_console_writer_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: directed and random console
// operations, each result checked against a cell-level prediction of the store.
// Depends on tcw_pkg and the text_console_writer RTL.

module text_console_writer_test;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  // The slowest single operation is a scroll over the full 128 x 64 store,
  // and this limit leaves ample margin for stalls on top.
  localparam int STALL_LIMIT = 50000;
  localparam logic [2:0] OP_FIRST_UNUSED = tcw_pkg::OP_READ + 3'd1;
  localparam logic [1:0] CFG_SPARE = tcw_pkg::CFG_ATTR + 2'd1;

  // One input transfer, lowest field last so that the packing matches in_tdata.
  typedef struct packed {
    logic [5:0] target_row;
    logic [6:0] target_col;
    logic [7:0] char_code;
    logic [2:0] opcode;
  } console_op_t;

  // One result transfer, packed to match out_tdata.
  typedef struct packed {
    logic [1:0] spare;
    logic [5:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
    logic       status;
  } console_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // opcode[2:0], char_code[7:0], target_col[6:0], target_row[5:0]
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // status, cell_char[7:0], cell_attr[7:0], cursor_col[6:0], cursor_row[5:0], 2 zero bits
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = tcw_pkg::CFG_COLUMNS;
  logic [7:0]  cfg_data = '0;

  // Shadow copy of the console: cell store, cursor and the three registers.
  logic [15:0] shadow_cells [MAX_ROWS*MAX_COLS];
  int unsigned shadow_col;
  int unsigned shadow_row;
  logic [7:0]  columns_reg;
  logic [6:0]  rows_reg;
  logic [7:0]  attr_reg;

  console_result_t pending_results [$];
  int          error_count = 0;
  // When set, neither side inserts idle cycles, giving back-to-back transfers.
  bit          steady_flow = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  text_console_writer #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the console.
  // ---------------------------------------------------------------------------

  // Columns and rows in use: zero acts as one, oversize values saturate.
  function automatic int unsigned area_cols();
    if (columns_reg == 0) return 1;
    return (columns_reg > MAX_COLS) ? MAX_COLS : columns_reg;
  endfunction

  function automatic int unsigned area_rows();
    if (rows_reg == 0) return 1;
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
  endfunction

  function automatic void reset_shadow();
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    shadow_col  = 0;
    shadow_row  = 0;
    columns_reg = tcw_pkg::COLUMNS_RST;
    rows_reg    = tcw_pkg::ROWS_RST;
    attr_reg    = tcw_pkg::ATTR_RST;
  endfunction

  // The stride is always MAX_COLS, so only the cells inside the area move and
  // anything stored beyond it stays where it is.
  function automatic void scroll_shadow();
    int unsigned nc;
    int unsigned nr;
    nc = area_cols();
    nr = area_rows();
    for (int unsigned r = 0; r + 1 < nr; r++)
      for (int unsigned c = 0; c < nc; c++)
        shadow_cells[r*MAX_COLS + c] = shadow_cells[(r + 1)*MAX_COLS + c];
    for (int unsigned c = 0; c < nc; c++)
      shadow_cells[(nr - 1)*MAX_COLS + c] = {attr_reg, 8'h00};
  endfunction

  function automatic void clear_shadow();
    int unsigned nc;
    int unsigned nr;
    nc = area_cols();
    nr = area_rows();
    for (int unsigned r = 0; r < nr; r++)
      for (int unsigned c = 0; c < nc; c++)
        shadow_cells[r*MAX_COLS + c] = {attr_reg, 8'h00};
    shadow_col = 0;
    shadow_row = 0;
  endfunction

  // A printable byte is only stored while the cursor lies inside the area,
  // yet the cursor advances regardless. Any print, even an ignored control
  // code, pulls a cursor below the area back to the last row with a scroll.
  function automatic void print_shadow(logic [7:0] ch);
    int unsigned nc;
    int unsigned nr;
    nc = area_cols();
    nr = area_rows();
    if (ch >= tcw_pkg::PRINTABLE_MIN) begin
      if (shadow_col < nc && shadow_row < nr)
        shadow_cells[shadow_row*MAX_COLS + shadow_col] = {attr_reg, ch};
      shadow_col++;
      if (shadow_col >= nc) begin
        shadow_col = 0;
        shadow_row++;
      end
    end else if (ch == tcw_pkg::NEWLINE_CODE) begin
      shadow_col = 0;
      shadow_row++;
    end
    if (shadow_row >= nr) begin
      shadow_row = nr - 1;
      scroll_shadow();
    end
  endfunction

  function automatic console_result_t console_apply(console_op_t op);
    console_result_t res;
    logic            on_screen;
    logic [15:0]     stored;
    res        = '0;
    res.status = tcw_pkg::STATUS_OK;
    on_screen  = (op.target_col < area_cols()) && (op.target_row < area_rows());
    case (op.opcode)
      tcw_pkg::OP_PRINT: print_shadow(op.char_code);
      tcw_pkg::OP_CLEAR: clear_shadow();
      tcw_pkg::OP_SETCUR: begin
        if (on_screen) begin
          shadow_col = op.target_col;
          shadow_row = op.target_row;
        end else begin
          res.status = tcw_pkg::STATUS_RANGE;
        end
      end
      tcw_pkg::OP_SCROLL: scroll_shadow();
      tcw_pkg::OP_READ: begin
        if (on_screen) begin
          stored        = shadow_cells[op.target_row*MAX_COLS + op.target_col];
          res.cell_char = stored[7:0];
          res.cell_attr = stored[15:8];
        end else begin
          res.status = tcw_pkg::STATUS_RANGE;
        end
      end
      default: ;  // unused opcodes change nothing
    endcase
    res.cursor_col = 7'(shadow_col);
    res.cursor_row = 6'(shadow_row);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle-cycle generation: mostly short gaps, now and then a long one.
  // ---------------------------------------------------------------------------

  function automatic int unsigned stall_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_gap();
    if (steady_flow || $urandom_range(0, 99) < 60) return 0;
    return stall_len();
  endfunction

  // The result side throttles out_tready on its own.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
      hold_cycles <= stall_len() - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: every result transfer is matched with the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    console_result_t want;
    console_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("cell_char", want.cell_char, got.cell_char);
        compare_field("cell_attr", want.cell_attr, got.cell_attr);
        compare_field("cursor_col", want.cursor_col, got.cursor_col);
        compare_field("cursor_row", want.cursor_row, got.cursor_row);
        compare_field("padding", want.spare, got.spare);
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on any channel means the
  // block has hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // Sends one operation and records its predicted result at the accepting
  // edge. in_tvalid is left high when no gap follows, so that consecutive
  // operations go out back to back.
  task automatic send_op(logic [2:0] opcode, logic [7:0] char_code,
                         logic [6:0] col, logic [5:0] row);
    console_op_t op;
    int unsigned gap;
    op.opcode     = opcode;
    op.char_code  = char_code;
    op.target_col = col;
    op.target_row = row;
    cfg_valid <= 1'b0;
    in_tdata  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(console_apply(op));
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes are issued back to back; cfg_valid drops with the next
  // operation or at the end of the run.
  task automatic write_reg(logic [1:0] index, logic [7:0] value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      tcw_pkg::CFG_COLUMNS: columns_reg = value;
      tcw_pkg::CFG_ROWS:    rows_reg = value[6:0];
      tcw_pkg::CFG_ATTR:    attr_reg = value;
      default:     ;  // spare index, no register behind it
    endcase
  endtask

  // Every operation yields a result, so once all results are in the block has
  // finished its work; in_tready then confirms it is back waiting for input.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_tready);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Default area of 80 x 30 with a zeroed store: reads at and just beyond the
  // corners, then a print into the very last cell, which wraps below the last
  // row and scrolls the screen.
  task automatic test_after_reset();
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd79, 6'd29);
    send_op(tcw_pkg::OP_READ, 8'hFF, 7'd80, 6'd0);
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd127, 6'd63);
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd79, 6'd29);
    send_op(tcw_pkg::OP_PRINT, 8'h41, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd79, 6'd28);
  endtask

  // Printable boundaries, newline, ignored control codes, unused opcodes,
  // scroll and clear in the default area.
  task automatic test_print_codes();
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, tcw_pkg::PRINTABLE_MIN, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, 8'hFF, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, tcw_pkg::PRINTABLE_MIN - 8'd1, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, 8'h00, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, tcw_pkg::NEWLINE_CODE, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, 8'h80, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd1, 6'd0);
    for (int k = 0; k < 3; k++)
      send_op(OP_FIRST_UNUSED + 3'(k), 8'hFF, 7'd127, 6'd63);
    send_op(tcw_pkg::OP_SCROLL, 8'h00, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_CLEAR, 8'h00, 7'd0, 6'd0);
  endtask

  // Register extremes: a one-cell area from zero sizes, oversize values that
  // saturate to the full store, and a cursor left outside after shrinking.
  task automatic test_register_extremes();
    settle();
    write_reg(tcw_pkg::CFG_ATTR, 8'h00);
    write_reg(tcw_pkg::CFG_COLUMNS, 8'h00);
    write_reg(tcw_pkg::CFG_ROWS, 8'h00);
    write_reg(CFG_SPARE, 8'hFF);
    send_op(tcw_pkg::OP_PRINT, 8'h5A, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd1, 6'd0);

    settle();
    write_reg(tcw_pkg::CFG_ATTR, 8'hFF);
    write_reg(tcw_pkg::CFG_COLUMNS, 8'hFF);
    write_reg(tcw_pkg::CFG_ROWS, 8'hFF);
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd127, 6'd63);
    send_op(tcw_pkg::OP_PRINT, 8'h7E, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd127, 6'd62);
    send_op(tcw_pkg::OP_CLEAR, 8'h00, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd100, 6'd50);

    // Shrink under the cursor: a control code still forces the scroll, and a
    // printable byte outside the area is dropped while the cursor wraps.
    settle();
    write_reg(tcw_pkg::CFG_COLUMNS, 8'd8);
    write_reg(tcw_pkg::CFG_ROWS, 8'd4);
    send_op(tcw_pkg::OP_PRINT, 8'h05, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_PRINT, 8'h2A, 7'd0, 6'd0);
    send_op(tcw_pkg::OP_READ, 8'h00, 7'd7, 6'd3);

    settle();
    write_reg(tcw_pkg::CFG_COLUMNS, 8'd128);
    write_reg(tcw_pkg::CFG_ROWS, 8'd64);
    send_op(tcw_pkg::OP_SETCUR, 8'h00, 7'd5, 6'd60);
    settle();
    write_reg(tcw_pkg::CFG_ROWS, 8'd4);
    send_op(tcw_pkg::OP_PRINT, tcw_pkg::NEWLINE_CODE, 7'd0, 6'd0);
  endtask

  // Random operations over a series of area settings. Most areas are small to
  // keep scrolls and clears short; a few phases sit at the size extremes. The
  // store is not cleared between phases, so old content outside a shrunken
  // area and cursors left outside it are exercised too.
  task automatic test_random_traffic();
    console_op_t op;
    int unsigned nc;
    int unsigned nr;
    int unsigned pick;
    logic [7:0]  col_value;
    logic [7:0]  row_value;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      steady_flow <= ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          col_value = 8'd128;
          row_value = 8'd2;
        end
        1: begin
          col_value = 8'd1;
          row_value = 8'd64;
        end
        2: begin
          col_value = 8'd0;
          row_value = 8'd0;
        end
        3: begin
          col_value = 8'd200;
          row_value = 8'd3;
        end
        4: begin
          // Bit 7 of the data is outside the rows register and is dropped.
          col_value = 8'd16;
          row_value = 8'h85;
        end
        default: begin
          col_value = 8'($urandom_range(2, 20));
          row_value = 8'($urandom_range(1, 8));
        end
      endcase
      write_reg(tcw_pkg::CFG_COLUMNS, col_value);
      write_reg(tcw_pkg::CFG_ROWS, row_value);
      write_reg(tcw_pkg::CFG_ATTR, 8'($urandom_range(0, 255)));
      nc = area_cols();
      nr = area_rows();

      for (int k = 0; k < 40; k++) begin
        // Fields an operation does not use still carry random bits.
        op   = console_op_t'(24'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          op.opcode = tcw_pkg::OP_PRINT;
          case ($urandom_range(0, 9))
            0:       op.char_code = tcw_pkg::NEWLINE_CODE;
            1:       op.char_code = 8'($urandom_range(0, 31));
            default: op.char_code = 8'($urandom_range(32, 255));
          endcase
        end else if (pick < 84) begin
          op.opcode = (pick < 67) ? tcw_pkg::OP_SETCUR : tcw_pkg::OP_READ;
          if ($urandom_range(0, 3) != 0) begin
            op.target_col = 7'($urandom_range(0, nc - 1));
            op.target_row = 6'($urandom_range(0, nr - 1));
          end
        end else if (pick < 89) begin
          op.opcode = tcw_pkg::OP_SCROLL;
        end else if (pick < 92) begin
          op.opcode = tcw_pkg::OP_CLEAR;
        end else begin
          op.opcode = OP_FIRST_UNUSED + 3'($urandom_range(0, 2));
        end
        send_op(op.opcode, op.char_code, op.target_col, op.target_row);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------

  initial begin
    reset_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The block sweeps its whole store after reset; the first transfer simply
    // waits for in_tready.
    test_after_reset();
    test_print_codes();
    test_register_extremes();
    test_random_traffic();

    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Keep the clock running to catch any stray result transfer.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
